[rtl/core/ptfr_pkg.sv]
// Shared types and constants for the pixel tile flip/rotate buffer.
`timescale 1ns / 1ps
`default_nettype none

package ptfr_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned ORIENT_W = 3;

  // Bit 0 mirrors physical rows, bit 1 mirrors physical columns, bit 2 transposes.
  localparam logic [ORIENT_W-1:0] OR_IDENTITY    = 3'b000;
  localparam logic [ORIENT_W-1:0] OR_MIRROR_ROWS = 3'b001;
  localparam logic [ORIENT_W-1:0] OR_MIRROR_COLS = 3'b010;
  localparam int unsigned         OR_TRANSPOSE_BIT = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE        = 3'd0,
    OP_READ         = 3'd1,
    OP_FLIP_VERT    = 3'd2,
    OP_FLIP_HORIZ   = 3'd3,
    OP_ROTATE_RIGHT = 3'd4,
    OP_RESET_ORIENT = 3'd5
  } opcode_e;

  typedef enum logic {
    REG_TILE_WIDTH  = 1'b0,
    REG_TILE_HEIGHT = 1'b1
  } reg_index_e;

  // Orientation after one command; unknown commands keep it.
  function automatic logic [ORIENT_W-1:0] next_orient(input logic [OPCODE_W-1:0] op,
                                                      input logic [ORIENT_W-1:0] cur);
    logic t;
    logic [ORIENT_W-1:0] nxt;
    t   = cur[OR_TRANSPOSE_BIT];
    nxt = cur;
    case (op)
      OP_FLIP_VERT:    nxt = cur ^ (t ? OR_MIRROR_COLS : OR_MIRROR_ROWS);
      OP_FLIP_HORIZ:   nxt = cur ^ (t ? OR_MIRROR_ROWS : OR_MIRROR_COLS);
      OP_ROTATE_RIGHT: begin
        if (t) begin
          nxt = cur ^ OR_MIRROR_COLS;
          nxt[OR_TRANSPOSE_BIT] = 1'b0;
        end else begin
          nxt = cur ^ OR_MIRROR_ROWS;
          nxt[OR_TRANSPOSE_BIT] = 1'b1;
        end
      end
      OP_RESET_ORIENT: nxt = OR_IDENTITY;
      default:         nxt = cur;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

[rtl/core/pixel_tile_flip_rotate.sv]
// Top level: tile buffer with orientation remapping, stream command port and APB registers.
`timescale 1ns / 1ps
`default_nettype none

// Tile buffer of MAX_DIM x MAX_DIM RGBA pixels seen through one of eight
// orientations (flips and quarter turns compose; pixels never move, addresses
// are remapped). One command is accepted every cycle unless a read is held
// back by a stalled result. A command passes an input register, where its
// logical position is mapped to a store address and the orientation is
// updated; a read is then registered in the store's read port, which drives
// its result beat. Only reads produce a result beat. A stalled result holds the
// next read in the input register, and that read holds back every command
// behind it; commands ahead of it keep flowing. The store is not cleared:
// read only pixels that were written. Program tile_width and tile_height while
// no command is in flight.
module pixel_tile_flip_rotate #(
  parameter int unsigned MAX_DIM = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command beat
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // row_index[5:0], col_index[11:6], pixel_in[43:12]
  input  wire logic [2:0]  s_axis_tuser,   // opcode[2:0]
  // result beat
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // pixel_out[31:0]
  output logic [0:0]       m_axis_tuser,   // out_of_range[0]
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ptfr_pkg::*;

  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CMP_W = (DIM_W > INDEX_W) ? DIM_W : INDEX_W;
  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  // ---------------- registers ----------------
  logic [SIZE_W-1:0] tile_width_q, tile_height_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_width_q  <= SIZE_W'(64);
      tile_height_q <= SIZE_W'(64);
    end else if (cfg_wr) begin
      case (reg_index_e'(paddr[2]))
        REG_TILE_WIDTH:  tile_width_q  <= pwdata[SIZE_W-1:0];
        REG_TILE_HEIGHT: tile_height_q <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_e'(paddr[2]))
      REG_TILE_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, tile_width_q};
      REG_TILE_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, tile_height_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic                v1_q;
  logic [OPCODE_W-1:0] op1_q;
  logic [INDEX_W-1:0]  row1_q, col1_q;
  logic [PIXEL_W-1:0]  px1_q;
  logic                adv1, s2_free, s_acc;
  logic                v2_q, oor2_q;
  logic [PIXEL_W-1:0]  rd2_q;
  logic [ORIENT_W-1:0] orient_q;

  assign s2_free       = !v2_q || m_axis_tready;
  assign adv1          = v1_q && ((op1_q != OP_READ) || s2_free);
  assign s_axis_tready = !v1_q || adv1;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op1_q  <= s_axis_tuser[OPCODE_W-1:0];
      row1_q <= s_axis_tdata[5:0];
      col1_q <= s_axis_tdata[11:6];
      px1_q  <= s_axis_tdata[43:12];
    end
  end

  // ---------------- address mapping ----------------
  logic [DIM_W-1:0] w_c, h_c, vw, vh;
  logic             tr, in_view;
  logic [IDX_W-1:0] pr0, pc0, pr, pc;
  logic [AW-1:0]    addr;

  always_comb begin
    // Size 0 acts as 1, anything above MAX_DIM acts as MAX_DIM.
    if (tile_width_q == '0)              w_c = DIM_W'(1);
    else if (int'(tile_width_q) > MAX_DIM) w_c = DIM_W'(MAX_DIM);
    else                                 w_c = DIM_W'(tile_width_q);
    if (tile_height_q == '0)              h_c = DIM_W'(1);
    else if (int'(tile_height_q) > MAX_DIM) h_c = DIM_W'(MAX_DIM);
    else                                  h_c = DIM_W'(tile_height_q);

    tr      = orient_q[OR_TRANSPOSE_BIT];
    vw      = tr ? h_c : w_c;
    vh      = tr ? w_c : h_c;
    in_view = (CMP_W'(row1_q) < CMP_W'(vh)) && (CMP_W'(col1_q) < CMP_W'(vw));

    pr0 = IDX_W'(tr ? col1_q : row1_q);
    pc0 = IDX_W'(tr ? row1_q : col1_q);
    pr  = (orient_q[0]) ? IDX_W'(h_c - DIM_W'(1) - DIM_W'(pr0)) : pr0;
    pc  = (orient_q[1]) ? IDX_W'(w_c - DIM_W'(1) - DIM_W'(pc0)) : pc0;
    addr = AW'(pr) * AW'(MAX_DIM) + AW'(pc);
  end

  // ---------------- orientation ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= OR_IDENTITY;
    end else if (adv1) begin
      orient_q <= next_orient(op1_q, orient_q);
    end
  end

  // ---------------- pixel store ----------------
  logic [PIXEL_W-1:0] store_q [DEPTH];
  logic               mem_we, mem_re;

  assign mem_we = adv1 && (op1_q == OP_WRITE) && in_view;
  assign mem_re = adv1 && (op1_q == OP_READ);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[addr] <= px1_q;
    end
    if (mem_re) begin
      rd2_q <= store_q[addr];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      oor2_q <= 1'b0;
    end else if (s2_free) begin
      v2_q <= mem_re;
      if (mem_re) begin
        oor2_q <= !in_view;
      end
    end
  end

  assign m_axis_tvalid   = v2_q;
  assign m_axis_tdata    = oor2_q ? '0 : rd2_q;
  assign m_axis_tuser[0] = oor2_q;

  // ---------------- assertions ----------------
  a_reset_orient: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv1 && op1_q == OP_RESET_ORIENT) |=> (orient_q == OR_IDENTITY))
    else $error("orientation not identity after reset-orientation command");

  a_rotate_transposes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv1 && op1_q == OP_ROTATE_RIGHT) |=>
      (orient_q[OR_TRANSPOSE_BIT] != $past(orient_q[OR_TRANSPOSE_BIT])))
    else $error("quarter turn did not swap view width and height");

  a_flip_keeps_transpose: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv1 && (op1_q == OP_FLIP_VERT || op1_q == OP_FLIP_HORIZ)) |=>
      (orient_q[OR_TRANSPOSE_BIT] == $past(orient_q[OR_TRANSPOSE_BIT])))
    else $error("flip changed the transpose bit");

  a_no_result_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && op1_q == OP_READ && v2_q && !m_axis_tready) |-> !adv1)
    else $error("read advanced over a held result");

endmodule

`default_nettype wire
